// ===== hw/rtl/cdq_pkg.sv =====
// shared types, constants and pointer helpers for the circular deque buffer
// no dependencies; used by circular_deque_buffer, cdq_checker and the testbench
package cdq_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DW    = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_PEEK       = 3'd4
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0]           req_type;
    logic signed [DW-1:0] push_value;
  } cdq_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [DW-1:0] front_value;
    logic signed [DW-1:0] back_value;
    logic                 is_empty;
    logic                 is_full;
  } cdq_rsp_t;

  // pointer steps modulo DEPTH
  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] idx);
    return (idx == '0) ? AW'(DEPTH - 1) : idx - AW'(1);
  endfunction

endpackage

// ===== hw/rtl/circular_deque_buffer.sv =====
// top level of the circular deque buffer: pointer control, end-value cache, result register
// depends on cdq_pkg and cdq_ram
//
// Double-ended queue of cdq_pkg::DEPTH signed 32-bit words held in one ram.
// Every request (push back, push front, pop back, pop front, peek) yields
// exactly one result with the status, the empty and full flags and the front
// and back words after the operation (both all ones while empty). A request
// passes through S_IDLE and S_EXEC: in the transfer cycle the pointers are
// updated and at most one ram access is issued (the write of a push, or the
// read of the new end word after a pop); in S_EXEC the registered ram word
// arrives and the result is loaded into the output register once it is free,
// and no new request is taken until then, as the ram read is registered.
// A result waiting in the output register does not block the next request;
// only a second finished result held back by a stalled consumer does. The
// front and back words are cached in registers, so a push never reads the
// ram. The ram is not cleared after reset; no entry is read before written.
module circular_deque_buffer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  cdq_pkg::cdq_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output cdq_pkg::cdq_rsp_t rsp_o
);

  // control state
  cdq_pkg::state_e         state_q, state_d;
  logic [cdq_pkg::AW-1:0]  front_q, front_d;
  logic [cdq_pkg::AW-1:0]  back_q, back_d;
  logic                    holds_q, holds_d;
  logic                    rd_front_q, rd_front_d;   // ram word is the new front
  logic                    rd_back_q, rd_back_d;     // ram word is the new back
  logic                    rsp_valid_q, rsp_valid_d;

  // payload state
  logic [1:0]              status_q, status_d;
  logic [cdq_pkg::DW-1:0]  fval_q, fval_d;           // cached front word
  logic [cdq_pkg::DW-1:0]  bval_q, bval_d;           // cached back word
  cdq_pkg::cdq_rsp_t       rsp_q, rsp_d;

  // ram port
  logic                    ram_we, ram_re;
  logic [cdq_pkg::AW-1:0]  ram_waddr, ram_raddr;
  logic [cdq_pkg::DW-1:0]  ram_rdata;

  logic                    full_w;
  logic                    out_free;
  logic                    load_rsp;
  logic [cdq_pkg::AW-1:0]  back_up, front_dn, back_dn, front_up;
  logic [cdq_pkg::DW-1:0]  fval_now, bval_now;

  cdq_ram #(
    .Depth (cdq_pkg::DEPTH),
    .Width (cdq_pkg::DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.push_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign back_up  = cdq_pkg::step_up(back_q);
  assign back_dn  = cdq_pkg::step_down(back_q);
  assign front_up = cdq_pkg::step_up(front_q);
  assign front_dn = cdq_pkg::step_down(front_q);

  // full flag of the current pointer state
  assign full_w   = holds_q && (back_up == front_q);

  // output register can take a result this cycle
  assign out_free = !rsp_valid_q || rsp_ready_i;

  // end words after the operation, ram word forwarded where a pop moved an end
  assign fval_now = rd_front_q ? ram_rdata : fval_q;
  assign bval_now = rd_back_q  ? ram_rdata : bval_q;

  assign req_ready_o = (state_q == cdq_pkg::S_IDLE);

  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    back_d     = back_q;
    holds_d    = holds_q;
    rd_front_d = rd_front_q;
    rd_back_d  = rd_back_q;
    status_d   = status_q;
    fval_d     = fval_q;
    bval_d     = bval_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    load_rsp   = 1'b0;

    case (state_q)
      cdq_pkg::S_IDLE: begin
        if (req_valid_i) begin
          state_d    = cdq_pkg::S_EXEC;
          status_d   = cdq_pkg::STAT_DONE;
          rd_front_d = 1'b0;
          rd_back_d  = 1'b0;
          case (req_i.req_type)
            cdq_pkg::REQ_PUSH_BACK,
            cdq_pkg::REQ_PUSH_FRONT: begin
              if (full_w) begin
                status_d = cdq_pkg::STAT_FULL;
              end else if (!holds_q) begin
                // first entry always lands at index zero
                front_d   = '0;
                back_d    = '0;
                holds_d   = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = '0;
                fval_d    = req_i.push_value;
                bval_d    = req_i.push_value;
              end else if (req_i.req_type == cdq_pkg::REQ_PUSH_BACK) begin
                back_d    = back_up;
                ram_we    = 1'b1;
                ram_waddr = back_up;
                bval_d    = req_i.push_value;
              end else begin
                front_d   = front_dn;
                ram_we    = 1'b1;
                ram_waddr = front_dn;
                fval_d    = req_i.push_value;
              end
            end
            cdq_pkg::REQ_POP_BACK,
            cdq_pkg::REQ_POP_FRONT: begin
              if (!holds_q) begin
                status_d = cdq_pkg::STAT_EMPTY;
              end else if (front_q == back_q) begin
                // last entry leaves, pointers return home
                front_d = '0;
                back_d  = '0;
                holds_d = 1'b0;
              end else if (req_i.req_type == cdq_pkg::REQ_POP_BACK) begin
                back_d    = back_dn;
                ram_re    = 1'b1;
                ram_raddr = back_dn;
                rd_back_d = 1'b1;
              end else begin
                front_d    = front_up;
                ram_re     = 1'b1;
                ram_raddr  = front_up;
                rd_front_d = 1'b1;
              end
            end
            default: begin
              // peek and unused codes change nothing
            end
          endcase
        end
      end
      cdq_pkg::S_EXEC: begin
        if (out_free) begin
          load_rsp   = 1'b1;
          state_d    = cdq_pkg::S_IDLE;
          fval_d     = fval_now;
          bval_d     = bval_now;
          rd_front_d = 1'b0;
          rd_back_d  = 1'b0;
        end
      end
      default: begin
        state_d = cdq_pkg::S_IDLE;
      end
    endcase
  end

  // result word built from the post-operation state
  always_comb begin
    rsp_d.status      = status_q;
    rsp_d.front_value = holds_q ? fval_now : '1;
    rsp_d.back_value  = holds_q ? bval_now : '1;
    rsp_d.is_empty    = !holds_q;
    rsp_d.is_full     = full_w;
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (load_rsp) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdq_pkg::S_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      holds_q     <= 1'b0;
      rd_front_q  <= 1'b0;
      rd_back_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      back_q      <= back_d;
      holds_q     <= holds_d;
      rd_front_q  <= rd_front_d;
      rd_back_q   <= rd_back_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    fval_q   <= fval_d;
    bval_q   <= bval_d;
    if (load_rsp) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== hw/rtl/cdq_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module cdq_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cdq_checker.sv =====
// port-level checker for the circular deque buffer and its bind to the top level
// depends on cdq_pkg and circular_deque_buffer
module cdq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              rsp_valid_o,
  input logic              rsp_ready_i,
  input cdq_pkg::cdq_rsp_t rsp_o
);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed while stalled");

  // empty deque reports all-ones end words
  a_empty_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.is_empty |-> (rsp_o.front_value == '1) && (rsp_o.back_value == '1))
    else $error("empty result with end words not all ones");

  // empty and full exclusive
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.is_empty && rsp_o.is_full))
    else $error("empty and full both set");

  // refused push leaves the deque full
  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status == cdq_pkg::STAT_FULL) |-> rsp_o.is_full)
    else $error("push refused but deque not full");

  // refused pop leaves the deque empty
  a_empty_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status == cdq_pkg::STAT_EMPTY) |-> rsp_o.is_empty)
    else $error("pop refused but deque not empty");

endmodule

bind circular_deque_buffer cdq_checker u_cdq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);

// ===== sim/tb_circular_deque_buffer.sv =====
// self-checking testbench for circular_deque_buffer: random and directed deque requests
// depends on cdq_pkg and the circular_deque_buffer and cdq_ram rtl; needs no other files
module tb_circular_deque_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  // request codes above peek are unused and behave as a peek
  localparam logic [2:0] REQ_UNUSED_LO  = 3'd5;
  localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI  = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MODE_SPAN = 200;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      req_valid_i = 1'b0;
  logic      req_ready_o;
  cdq_req_t  req_i = '0;
  logic      rsp_valid_o;
  logic      rsp_ready_i = 1'b0;
  cdq_rsp_t  rsp_o;

  circular_deque_buffer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // stimulus waiting to be offered, and results the deque should still return
  cdq_req_t pending_reqs[$];
  cdq_rsp_t expected_rsps[$];

  // shadow copy of the deque contents and pointers
  logic [DW-1:0] dq_words [DEPTH];
  int unsigned   dq_head = 0;
  int unsigned   dq_tail = 0;
  bit            dq_live = 1'b0;
  int unsigned   dq_count = 0;

  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count = 0;
  int unsigned fail_count = 0;
  int unsigned total_reqs = 0;
  int unsigned refused_full = 0;
  int unsigned refused_empty = 0;
  int unsigned peak_count = 0;
  int unsigned gen_fill = 0;
  bit          req_took = 1'b0;
  bit          hold_off = 1'b0;
  bit          stim_done = 1'b0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  function automatic bit deque_is_full();
    return dq_live && ((dq_tail + 1) % DEPTH == dq_head);
  endfunction

  // advance the shadow deque by one request and return the result it must produce
  function automatic cdq_rsp_t apply_request(input cdq_req_t rq);
    cdq_rsp_t r;
    status_e  st;
    st = STAT_DONE;
    case (rq.req_type)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (deque_is_full()) begin
          st = STAT_FULL;
        end else if (!dq_live) begin
          // first entry always lands at index zero
          dq_head = 0;
          dq_tail = 0;
          dq_live = 1'b1;
          dq_words[0] = rq.push_value;
        end else if (rq.req_type == REQ_PUSH_BACK) begin
          dq_tail = (dq_tail + 1) % DEPTH;
          dq_words[dq_tail] = rq.push_value;
        end else begin
          dq_head = (dq_head + DEPTH - 1) % DEPTH;
          dq_words[dq_head] = rq.push_value;
        end
        if (st == STAT_DONE) dq_count++;
      end
      REQ_POP_BACK, REQ_POP_FRONT: begin
        if (!dq_live) begin
          st = STAT_EMPTY;
        end else if (dq_head == dq_tail) begin
          // last entry gone: pointers return home
          dq_live = 1'b0;
          dq_head = 0;
          dq_tail = 0;
        end else if (rq.req_type == REQ_POP_BACK) begin
          dq_tail = (dq_tail + DEPTH - 1) % DEPTH;
        end else begin
          dq_head = (dq_head + 1) % DEPTH;
        end
        if (st == STAT_DONE) dq_count--;
      end
      default: ;
    endcase
    if (st == STAT_FULL) refused_full++;
    if (st == STAT_EMPTY) refused_empty++;
    if (dq_count > peak_count) peak_count = dq_count;
    r.status      = st;
    r.front_value = dq_live ? dq_words[dq_head] : '1;
    r.back_value  = dq_live ? dq_words[dq_tail] : '1;
    r.is_empty    = !dq_live;
    r.is_full     = deque_is_full();
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [DW-1:0] exp_v,
                                      input logic [DW-1:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_v, act_v);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  // queue one request and keep a running guess of the occupancy to steer phases
  task automatic queue_req(input logic [2:0] kind, input logic [DW-1:0] value);
    cdq_req_t rq;
    rq.req_type   = kind;
    rq.push_value = value;
    pending_reqs.push_back(rq);
    total_reqs++;
    if ((kind == REQ_PUSH_BACK || kind == REQ_PUSH_FRONT) && gen_fill < DEPTH) gen_fill++;
    if ((kind == REQ_POP_BACK || kind == REQ_POP_FRONT) && gen_fill > 0) gen_fill--;
  endtask

  // random word with a bias toward the signed extremes
  function automatic logic [DW-1:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // pick an operation from push / pop percentages; the remainder is peeks and unused codes
  function automatic logic [2:0] pick_kind(input int unsigned push_pct,
                                           input int unsigned pop_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_pct) return $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    if (r < push_pct + pop_pct) return $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
    if ($urandom_range(3) == 0) return 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
    return REQ_PEEK;
  endfunction

  initial begin
    // directed: empty-deque reads, refused pops, unused codes, front wrap, last-entry pops
    queue_req(REQ_PEEK, rand_word());
    queue_req(REQ_POP_BACK, rand_word());
    queue_req(REQ_POP_FRONT, rand_word());
    queue_req(REQ_UNUSED_LO, rand_word());
    queue_req(REQ_UNUSED_MID, rand_word());
    queue_req(REQ_UNUSED_HI, rand_word());
    queue_req(REQ_PUSH_BACK, 32'h7fff_ffff);
    queue_req(REQ_PUSH_FRONT, 32'h8000_0000);  // front pointer wraps down past zero
    queue_req(REQ_PEEK, '0);
    queue_req(REQ_PUSH_BACK, '1);
    queue_req(REQ_PUSH_FRONT, '0);
    queue_req(REQ_POP_FRONT, rand_word());
    queue_req(REQ_POP_BACK, rand_word());
    queue_req(REQ_POP_BACK, rand_word());
    queue_req(REQ_POP_FRONT, rand_word());      // last entry leaves
    queue_req(REQ_POP_FRONT, rand_word());
    queue_req(REQ_PUSH_FRONT, 32'h5555_aaaa);   // push front into an empty deque
    queue_req(REQ_UNUSED_HI, rand_word());
    queue_req(REQ_POP_BACK, rand_word());
    queue_req(REQ_PUSH_BACK, 32'haaaa_5555);
    queue_req(REQ_PUSH_BACK, rand_word());
    queue_req(REQ_POP_BACK, rand_word());
    queue_req(REQ_POP_FRONT, rand_word());

    // low occupancy churn, often running dry
    repeat (250) queue_req(pick_kind(40, 45), rand_word());

    // fill the deque up to full, then knock on it a few times
    while (gen_fill < DEPTH) queue_req(pick_kind(96, 2), rand_word());
    repeat (8) queue_req(pick_kind(100, 0), rand_word());

    // hover around full: refusals, wraps in both directions
    repeat (260) queue_req(pick_kind(50, 45), rand_word());
    stim_done = 1'b1;
  end

  // idling profile by stimulus position: none, sender idle, receiver stall, both
  always_comb begin
    case ((sent_count / MODE_SPAN) % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
      default: begin send_idle_pct = 28; recv_stall_pct = 28; end
    endcase
  end

  // ---------------------------------------------------------------------------
  // driver: request side, changes at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!req_valid_i || req_took)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_i <= pending_reqs.pop_front();
        req_valid_i <= 1'b1;
        sent_count++;
      end else begin
        req_valid_i <= 1'b0;
      end
    end
  end

  // result side ready, with random stalls and the long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rsp_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-offs while requests keep coming, so the block backs up
  initial begin
    wait (sent_count >= 820);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
    wait (sent_count >= 1450);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both transfers at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cdq_rsp_t exp_rsp;
    cycle_count++;
    req_took = rst_ni && req_valid_i && req_ready_o;

    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (expected_rsps.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing expected, got %0h", $realtime, rsp_o);
      end else begin
        exp_rsp = expected_rsps.pop_front();
        check_field("status", DW'(exp_rsp.status), DW'(rsp_o.status));
        check_field("front_value", exp_rsp.front_value, rsp_o.front_value);
        check_field("back_value", exp_rsp.back_value, rsp_o.back_value);
        check_field("is_empty", DW'(exp_rsp.is_empty), DW'(rsp_o.is_empty));
        check_field("is_full", DW'(exp_rsp.is_full), DW'(rsp_o.is_full));
        checked_count++;
      end
    end

    // results come back only after the request is registered, so predicting after the check is safe
    if (req_took) begin
      expected_rsps.push_back(apply_request(req_i));
      accepted_count++;
    end
  end

  // reset, then wait for every request to be answered
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (!stim_done || accepted_count < total_reqs || expected_rsps.size() > 0)
      @(posedge clk_i);
    // stray results after the last one would show up here
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests, %0d results checked, peak occupancy %0d of %0d",
             accepted_count, checked_count, peak_count, DEPTH);
    $display("refused pushes on full deque %0d, refused pops on empty deque %0d",
             refused_full, refused_empty);
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard
  always @(posedge clk_i) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
